>>> rtl/tlvefx_pkg.sv
// ----------------------------------------------------------------------------
// TLV EEPROM field extractor - shared definitions
// Parse phases, result status codes and image layout constants.
// ----------------------------------------------------------------------------
package tlvefx_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 17;
    localparam int STAT_W = 2;

    // Image layout: 11-byte header, big-endian data length in bytes 9 and 10
    localparam logic [POS_W-1:0] HDR_LEN    = 17'd11;
    localparam logic [POS_W-1:0] LEN_HI_POS = 17'd9;
    localparam logic [POS_W-1:0] LEN_LO_POS = 17'd10;

    typedef enum logic [2:0] {
        PH_DONE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_TYPE   = 3'd2,
        PH_LEN    = 3'd3,
        PH_VALUE  = 3'd4,
        PH_SKIP   = 3'd5
    } t_phase;

    localparam logic [STAT_W-1:0] ST_VALUE = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd2;

endpackage

>>> rtl/tlvefx_if.sv
// ----------------------------------------------------------------------------
// TLV EEPROM field extractor - stream interfaces
// Valid/ready channels for image bytes in and extracted results out.
// ----------------------------------------------------------------------------
interface tlvefx_byte_if;
    logic                             valid;
    logic                             ready;
    logic [tlvefx_pkg::BYTE_W-1:0]    eeprom_byte;
    logic                             frame_start;

    modport source (output valid, output eeprom_byte, output frame_start, input ready);
    modport sink   (input valid, input eeprom_byte, input frame_start, output ready);
endinterface

interface tlvefx_result_if;
    logic                             valid;
    logic                             ready;
    logic [tlvefx_pkg::BYTE_W-1:0]    value_byte;
    logic                             value_last;
    logic [tlvefx_pkg::STAT_W-1:0]    status;

    modport source (output valid, output value_byte, output value_last, output status,
                    input ready);
    modport sink   (input valid, input value_byte, input value_last, input status,
                    output ready);
endinterface

>>> rtl/tlv_eeprom_field_extractor_top.sv
// ----------------------------------------------------------------------------
// TLV EEPROM field extractor
// Walks the type/length/value records of an EEPROM image and returns the
// value bytes of the record whose type matches the configured code.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Payload
//  --------  ---  -----------------  ------------------------------------------
//  i_byte    in   valid / ready      eeprom_byte[7:0], frame_start
//  o_result  out  valid / ready      value_byte[7:0], value_last, status[1:0]
//  cfg       in   i_cfg_we (no wait) i_cfg_wdata[7:0] -> wanted type code
//
//  One byte per cycle while the output is not stalled: each input beat is parsed in
//  the cycle it arrives and any result lands in the output register on the same edge.
//  A beat causes at most one result; the output register lets the next byte
//  in whenever it is empty or being drained in that cycle.
//  Reset (synchronous, active low) leaves the parser in its done phase,
//  ignoring bytes until one carries frame_start, and clears the wanted type.
//  A stalled result holds the input back for as long as it is not taken.
// ----------------------------------------------------------------------------
module tlv_eeprom_field_extractor_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tlvefx_byte_if.sink                   i_byte,
    tlvefx_result_if.source               o_result,
    input  logic                          i_cfg_we,
    input  logic [tlvefx_pkg::BYTE_W-1:0] i_cfg_wdata
);

    localparam int POS_W  = tlvefx_pkg::POS_W;
    localparam int BYTE_W = tlvefx_pkg::BYTE_W;

    // Parser state
    tlvefx_pkg::t_phase       r_phase,     n_phase;
    logic [POS_W-1:0]         r_pos,       n_pos;
    logic [POS_W-1:0]         r_data_end,  n_data_end;
    logic [BYTE_W-1:0]        r_left,      n_left;
    logic                     r_match,     n_match;
    logic [BYTE_W-1:0]        r_wanted;

    // Result register
    logic                              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]                 r_out_byte,  n_out_byte;
    logic                              r_out_last,  n_out_last;
    logic [tlvefx_pkg::STAT_W-1:0]     r_out_stat,  n_out_stat;

    logic                     in_beat;
    logic                     out_beat;
    tlvefx_pkg::t_phase       cur_phase;
    logic [POS_W-1:0]         cur_pos;
    logic [POS_W-1:0]         end_sum;
    logic [POS_W:0]           next_rec;
    logic [BYTE_W-1:0]        left_dec;
    logic                     emit;
    logic [BYTE_W-1:0]        emit_byte;
    logic                     emit_last;
    logic [tlvefx_pkg::STAT_W-1:0] emit_stat;

    // Take a byte whenever the result register is free or drains this cycle
    assign i_byte.ready      = !r_out_valid || o_result.ready;
    assign in_beat           = i_byte.valid && i_byte.ready;
    assign out_beat          = r_out_valid && o_result.ready;

    assign o_result.valid      = r_out_valid;
    assign o_result.value_byte = r_out_byte;
    assign o_result.value_last = r_out_last;
    assign o_result.status     = r_out_stat;

    // A frame start restarts the header at byte 0, whatever the current phase
    assign cur_phase = i_byte.frame_start ? tlvefx_pkg::PH_HEADER : r_phase;
    assign cur_pos   = i_byte.frame_start ? '0 : r_pos;

    // Data end = length + header, taken modulo the position range
    assign end_sum   = r_data_end + {{(POS_W-BYTE_W){1'b0}}, i_byte.eeprom_byte}
                       + tlvefx_pkg::HDR_LEN;
    // Start of the following record, one bit wider so it never wraps
    assign next_rec  = {1'b0, cur_pos} + {{(POS_W+1-BYTE_W){1'b0}}, i_byte.eeprom_byte}
                       + {{POS_W{1'b0}}, 1'b1};
    assign left_dec  = r_left - {{(BYTE_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_data_end = r_data_end;
        n_left     = r_left;
        n_match    = r_match;
        emit       = 1'b0;
        emit_byte  = '0;
        emit_last  = 1'b0;
        emit_stat  = tlvefx_pkg::ST_VALUE;

        // Bytes in the done phase without a frame start leave everything alone
        if (in_beat && cur_phase != tlvefx_pkg::PH_DONE) begin
            n_phase = cur_phase;
            n_pos   = cur_pos + {{(POS_W-1){1'b0}}, 1'b1};
            unique case (cur_phase)
                tlvefx_pkg::PH_HEADER: begin
                    if (cur_pos == tlvefx_pkg::LEN_HI_POS) begin
                        n_data_end = {1'b0, i_byte.eeprom_byte, {BYTE_W{1'b0}}};
                    end else if (cur_pos == tlvefx_pkg::LEN_LO_POS) begin
                        n_data_end = end_sum;
                        // Zero data length: nothing to search
                        if (end_sum <= tlvefx_pkg::HDR_LEN) begin
                            emit      = 1'b1;
                            emit_stat = tlvefx_pkg::ST_MISS;
                            n_phase   = tlvefx_pkg::PH_DONE;
                        end else begin
                            n_phase   = tlvefx_pkg::PH_TYPE;
                        end
                    end
                end
                tlvefx_pkg::PH_TYPE: begin
                    n_match = (i_byte.eeprom_byte == r_wanted);
                    n_phase = tlvefx_pkg::PH_LEN;
                end
                tlvefx_pkg::PH_LEN: begin
                    if (r_match) begin
                        if (i_byte.eeprom_byte == '0) begin
                            emit      = 1'b1;
                            emit_stat = tlvefx_pkg::ST_EMPTY;
                            n_phase   = tlvefx_pkg::PH_DONE;
                        end else begin
                            n_left    = i_byte.eeprom_byte;
                            n_phase   = tlvefx_pkg::PH_VALUE;
                        end
                    end else if (next_rec >= {1'b0, r_data_end}) begin
                        // Next record would start at or past the end
                        emit      = 1'b1;
                        emit_stat = tlvefx_pkg::ST_MISS;
                        n_phase   = tlvefx_pkg::PH_DONE;
                    end else if (i_byte.eeprom_byte == '0) begin
                        n_phase   = tlvefx_pkg::PH_TYPE;
                    end else begin
                        n_left    = i_byte.eeprom_byte;
                        n_phase   = tlvefx_pkg::PH_SKIP;
                    end
                end
                tlvefx_pkg::PH_VALUE: begin
                    n_left    = left_dec;
                    emit      = 1'b1;
                    emit_byte = i_byte.eeprom_byte;
                    emit_stat = tlvefx_pkg::ST_VALUE;
                    if (left_dec == '0) begin
                        emit_last = 1'b1;
                        n_phase   = tlvefx_pkg::PH_DONE;
                    end
                end
                tlvefx_pkg::PH_SKIP: begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = tlvefx_pkg::PH_TYPE;
                    end
                end
                default: begin
                    n_phase = tlvefx_pkg::PH_DONE;
                end
            endcase
        end
    end

    // Load a new result, else drop the old one once taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_stat  = r_out_stat;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = emit_byte;
            n_out_last  = emit_last;
            n_out_stat  = emit_stat;
        end else if (out_beat) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tlvefx_pkg::PH_DONE;
            r_pos       <= '0;
            r_data_end  <= '0;
            r_left      <= '0;
            r_match     <= 1'b0;
            r_wanted    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_data_end  <= n_data_end;
            r_left      <= n_left;
            r_match     <= n_match;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_wanted <= i_cfg_wdata;
            end
        end
    end

    // Result payload carries no reset
    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_stat <= n_out_stat;
    end

endmodule
